// ===== hdl/indexed_double_ended_queue_assert.svh =====
// Assertion macros for the indexed double-ended queue.
// Bodies refer to i_clk and i_rst_n of the module that includes this header.
`ifndef INDEXED_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define INDEXED_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define IDQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("idq assertion failed");

// Implication whose consequent is checked later than the antecedent.
`define IDQ_ASSERT_DLY2(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##2 (cons)) else $error("idq assertion failed");

`endif

// ===== hdl/idq_pkg.sv =====
// Shared constants, codes and types of the indexed double-ended queue.
// No dependencies.
`timescale 1ns / 1ps

package idq_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
    localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;
    localparam logic [OP_W-1:0] OP_READ       = 3'd7;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // Broadcast to every cell: open a gap at pos, or close the one at pos.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] pos;
    } t_cell_ctl;

endpackage

// ===== hdl/idq_cell.sv =====
// One storage cell of the queue chain: holds a word, shifts to/from neighbors.
// Depends on idq_pkg.
`timescale 1ns / 1ps

module idq_cell (
    input  logic                      i_clk,
    input  idq_pkg::t_cell_ctl        i_ctl,
    input  logic [idq_pkg::IDX_W-1:0] i_index,
    input  logic [idq_pkg::DATA_W-1:0] i_value,
    input  logic [idq_pkg::DATA_W-1:0] i_left,
    input  logic [idq_pkg::DATA_W-1:0] i_right,
    input  logic [idq_pkg::IDX_W-1:0] i_back_addr,
    input  logic [idq_pkg::IDX_W-1:0] i_read_addr,
    output logic [idq_pkg::DATA_W-1:0] o_word,
    output logic [idq_pkg::DATA_W-1:0] o_back_tap,
    output logic [idq_pkg::DATA_W-1:0] o_read_tap
);

    logic [idq_pkg::DATA_W-1:0] r_word;
    logic [idq_pkg::DATA_W-1:0] n_word;

    always_comb begin
        priority if (i_ctl.ins && (i_index == i_ctl.pos)) begin
            n_word = i_value;
        end else if (i_ctl.ins && (i_index > i_ctl.pos)) begin
            n_word = i_left;
        end else if (i_ctl.rem && (i_index >= i_ctl.pos)) begin
            n_word = i_right;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word     = r_word;
    // Taps are zero unless this cell is addressed; the top ORs them together.
    assign o_back_tap = r_word & {idq_pkg::DATA_W{i_index == i_back_addr}};
    assign o_read_tap = r_word & {idq_pkg::DATA_W{i_index == i_read_addr}};

endmodule

// ===== hdl/indexed_double_ended_queue.sv =====
// Indexed double-ended queue: a chain of CAPACITY cells shifted in place.
// Strobe follows start via r_pend, r_o_valid. Throughput: one item per cycle unless busy;
// the chain shifts from pos on in the accept cycle, the result stage reads it the next.
// busy is high only during reset and until r_ready is set after it; results cannot be stalled.
// Reset clears the entry count and the result strobe; stored words are not cleared.
// Depends on idq_pkg, idq_cell and indexed_double_ended_queue_assert.svh.
`timescale 1ns / 1ps

module indexed_double_ended_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [idq_pkg::OP_W-1:0]    i_operation,
    input  logic [idq_pkg::POS_W-1:0]   i_position,
    input  logic [idq_pkg::DATA_W-1:0]  i_value,
    output logic                        o_valid,
    output logic [idq_pkg::CNT_W-1:0]   o_count,
    output logic                        o_is_empty,
    output logic [idq_pkg::DATA_W-1:0]  o_front_value,
    output logic [idq_pkg::DATA_W-1:0]  o_back_value,
    output logic [idq_pkg::DATA_W-1:0]  o_read_value,
    output logic                        o_read_valid,
    output logic [idq_pkg::ST_W-1:0]    o_status
);

    localparam int N = idq_pkg::CAPACITY;
    localparam int W = idq_pkg::DATA_W;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic                        r_ready;
    logic [idq_pkg::CNT_W-1:0]   r_count;
    logic [idq_pkg::CNT_W-1:0]   n_count;
    logic                        acc;

    // Accept-stage bookkeeping carried to the result stage
    logic                        r_pend;
    logic [idq_pkg::OP_W-1:0]    r_op;
    logic [idq_pkg::POS_W-1:0]   r_pos;
    logic [idq_pkg::ST_W-1:0]    r_status;
    logic [idq_pkg::ST_W-1:0]    n_status;

    idq_pkg::t_cell_ctl          cell_ctl;
    idq_pkg::t_cell_ctl          n_ctl;

    assign busy = ~r_ready;
    assign acc  = start & r_ready;

    // ------------------------------------------------------------------
    // Decode: where to open or close a gap in the chain
    // ------------------------------------------------------------------
    logic                        full;
    logic                        empty;
    logic [idq_pkg::IDX_W-1:0]   last_idx;   // count - 1, valid when not empty
    logic [idq_pkg::IDX_W-1:0]   tail_idx;   // count, valid when not full
    logic                        pos_past;   // position at or beyond count

    assign full     = (r_count == idq_pkg::CNT_W'(N));
    assign empty    = (r_count == '0);
    assign last_idx = idq_pkg::IDX_W'(r_count - idq_pkg::CNT_W'(1));
    assign tail_idx = idq_pkg::IDX_W'(r_count);
    assign pos_past = (32'(i_position) >= 32'(r_count));

    always_comb begin
        n_ctl    = '0;
        n_status = idq_pkg::ST_OK;
        n_count  = r_count;
        unique case (i_operation)
            idq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = idq_pkg::ST_FULL;
                end else begin
                    n_ctl.ins = 1'b1;
                    n_ctl.pos = '0;
                    n_count   = r_count + idq_pkg::CNT_W'(1);
                end
            end
            idq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_status = idq_pkg::ST_FULL;
                end else begin
                    n_ctl.ins = 1'b1;
                    n_ctl.pos = tail_idx;
                    n_count   = r_count + idq_pkg::CNT_W'(1);
                end
            end
            idq_pkg::OP_INSERT: begin
                if (full) begin
                    n_status = idq_pkg::ST_FULL;
                end else begin
                    n_ctl.ins = 1'b1;
                    n_ctl.pos = pos_past ? tail_idx : idq_pkg::IDX_W'(i_position);
                    n_count   = r_count + idq_pkg::CNT_W'(1);
                end
            end
            idq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_status = idq_pkg::ST_EMPTY;
                end else begin
                    n_ctl.rem = 1'b1;
                    n_ctl.pos = '0;
                    n_count   = r_count - idq_pkg::CNT_W'(1);
                end
            end
            idq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    n_status = idq_pkg::ST_EMPTY;
                end else begin
                    // Removing the last entry needs no shift, only the count.
                    n_count = r_count - idq_pkg::CNT_W'(1);
                end
            end
            idq_pkg::OP_ERASE: begin
                if (empty) begin
                    n_status = idq_pkg::ST_EMPTY;
                end else begin
                    n_ctl.rem = 1'b1;
                    n_ctl.pos = pos_past ? last_idx : idq_pkg::IDX_W'(i_position);
                    n_count   = r_count - idq_pkg::CNT_W'(1);
                end
            end
            idq_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            idq_pkg::OP_READ: begin
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Only an accepted transfer moves the chain.
    always_comb begin
        cell_ctl     = n_ctl;
        cell_ctl.ins = n_ctl.ins & acc;
        cell_ctl.rem = n_ctl.rem & acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_pend  <= acc;
            if (acc) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op     <= i_operation;
            r_pos    <= i_position;
            r_status <= n_status;
        end
    end

    // ------------------------------------------------------------------
    // Result-stage addresses, taken from the count after the operation
    // ------------------------------------------------------------------
    logic [idq_pkg::IDX_W-1:0]   back_addr;
    logic [idq_pkg::IDX_W-1:0]   read_addr;

    assign back_addr = last_idx;
    assign read_addr = (32'(r_pos) >= 32'(r_count)) ? last_idx
                                                    : idq_pkg::IDX_W'(r_pos);

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    logic [N-1:0][W-1:0] words;
    logic [N-1:0][W-1:0] back_taps;
    logic [N-1:0][W-1:0] read_taps;

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [W-1:0] left_w;
        logic [W-1:0] right_w;

        if (g == 0) begin : g_head
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = words[g-1];
        end

        // Last cell keeps its word on a close; it falls outside the count.
        if (g == N - 1) begin : g_tail
            assign right_w = words[g];
        end else begin : g_mid_r
            assign right_w = words[g+1];
        end

        idq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_index     (idq_pkg::IDX_W'(g)),
            .i_value     (i_value),
            .i_left      (left_w),
            .i_right     (right_w),
            .i_back_addr (back_addr),
            .i_read_addr (read_addr),
            .o_word      (words[g]),
            .o_back_tap  (back_taps[g]),
            .o_read_tap  (read_taps[g])
        );
    end

    // OR of the one-hot taps, bit by bit across the chain
    logic [W-1:0] back_word;
    logic [W-1:0] read_word;

    always_comb begin
        for (int b = 0; b < W; b++) begin
            logic [N-1:0] col_back;
            logic [N-1:0] col_read;
            for (int c = 0; c < N; c++) begin
                col_back[c] = back_taps[c][b];
                col_read[c] = read_taps[c][b];
            end
            back_word[b] = |col_back;
            read_word[b] = |col_read;
        end
    end

    // ------------------------------------------------------------------
    // Result registers: one-cycle strobe, receiver cannot stall
    // ------------------------------------------------------------------
    logic                        have;
    logic                        is_read;
    logic                        r_o_valid;
    logic [idq_pkg::CNT_W-1:0]   r_o_count;
    logic                        r_o_is_empty;
    logic [W-1:0]                r_o_front;
    logic [W-1:0]                r_o_back;
    logic [W-1:0]                r_o_read;
    logic                        r_o_read_valid;
    logic [idq_pkg::ST_W-1:0]    r_o_status;

    assign have    = (r_count != '0);
    assign is_read = (r_op == idq_pkg::OP_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_o_count      <= r_count;
            r_o_is_empty   <= ~have;
            r_o_front      <= have ? words[0] : '0;
            r_o_back       <= have ? back_word : '0;
            r_o_read       <= (have && is_read) ? read_word : '0;
            r_o_read_valid <= have && is_read;
            r_o_status     <= r_status;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_count       = r_o_count;
    assign o_is_empty    = r_o_is_empty;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;
    assign o_read_value  = r_o_read;
    assign o_read_valid  = r_o_read_valid;
    assign o_status      = r_o_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A refused push at the back must report full with the full count.
    logic drop_at_back;
    logic full_reported;

    assign drop_at_back  = acc && full && (i_operation == idq_pkg::OP_PUSH_BACK);
    assign full_reported = (r_o_status == idq_pkg::ST_FULL)
                           && (r_o_count == idq_pkg::CNT_W'(N));

`include "indexed_double_ended_queue_assert.svh"

    `IDQ_ASSERT_DLY2(a_result_follows, acc, r_o_valid)
    `IDQ_ASSERT_IMP(a_count_bound, 1'b1, 32'(r_count) <= N)
    `IDQ_ASSERT_IMP(a_empty_flag, r_o_valid, r_o_is_empty == (r_o_count == '0))
    `IDQ_ASSERT_DLY2(a_full_drop, drop_at_back, full_reported)
    `IDQ_ASSERT_IMP(a_read_valid_count, r_o_valid && r_o_read_valid, r_o_count != '0)

endmodule

// ===== verif/indexed_double_ended_queue_tb.sv =====
// Self-checking testbench for the indexed double-ended queue.
// Depends on idq_pkg and indexed_double_ended_queue; keeps its own deque model.
`timescale 1ns / 1ps

module indexed_double_ended_queue_tb;

    import idq_pkg::*;

    // Delay by which the result strobe trails the start transfer.
    localparam int RESULT_LATENCY = 2;
    // Cycles with neither a start transfer nor a result before giving up.
    // The slowest legal stretch is the longest random sender gap plus the pipeline.
    localparam int WATCHDOG_LIMIT = 400;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    // One result transfer, field for field as the block reports it.
    typedef struct {
        logic [CNT_W-1:0]  count;
        logic              is_empty;
        logic [DATA_W-1:0] front_value;
        logic [DATA_W-1:0] back_value;
        logic [DATA_W-1:0] read_value;
        logic              read_valid;
        logic [ST_W-1:0]   status;
    } t_queue_snapshot;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic [OP_W-1:0]     i_operation = OP_READ;
    logic [POS_W-1:0]    i_position  = '0;
    logic [DATA_W-1:0]   i_value     = '0;
    logic                busy;
    logic                o_valid;
    logic [CNT_W-1:0]    o_count;
    logic                o_is_empty;
    logic [DATA_W-1:0]   o_front_value;
    logic [DATA_W-1:0]   o_back_value;
    logic [DATA_W-1:0]   o_read_value;
    logic                o_read_valid;
    logic [ST_W-1:0]     o_status;

    // Model contents, front at index 0, and the results still to arrive.
    logic [DATA_W-1:0]   stored_words[$];
    t_queue_snapshot     awaited_snapshots[$];

    // When set the sender issues items with no gap between transfers.
    bit                  back_to_back = 1'b0;

    int                  mismatch_count  = 0;
    int                  items_sent      = 0;
    int                  results_checked = 0;
    int                  full_drops      = 0;
    int                  empty_ignores   = 0;
    int                  peak_depth      = 0;
    int                  stall_cycles    = 0;
    int                  op_tally[8];

    indexed_double_ended_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_read_value  (o_read_value),
        .o_read_valid  (o_read_valid),
        .o_status      (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deque model
    // ------------------------------------------------------------------

    // Insert with the end rules: a position at or past the count lands at the back.
    function automatic logic [ST_W-1:0] place_word(input int pos, input logic [DATA_W-1:0] word);
        if (stored_words.size() >= CAPACITY)
            return ST_FULL;
        if (pos > stored_words.size())
            pos = stored_words.size();
        stored_words.insert(pos, word);
        return ST_OK;
    endfunction

    // Removal clamps the position to the last entry; nothing happens when empty.
    function automatic logic [ST_W-1:0] drop_word(input int pos);
        if (stored_words.size() == 0)
            return ST_EMPTY;
        if (pos >= stored_words.size())
            pos = stored_words.size() - 1;
        stored_words.delete(pos);
        return ST_OK;
    endfunction

    // Applies one operation to the model and returns the result it must produce.
    function automatic t_queue_snapshot perform_queue_op(input logic [OP_W-1:0] op,
                                                         input logic [POS_W-1:0] pos,
                                                         input logic [DATA_W-1:0] word);
        t_queue_snapshot snap;
        int              depth;
        int              idx;
        snap.read_value = '0;
        snap.read_valid = 1'b0;
        snap.status     = ST_OK;
        case (op)
            OP_PUSH_FRONT: snap.status = place_word(0, word);
            OP_PUSH_BACK:  snap.status = place_word(stored_words.size(), word);
            OP_POP_FRONT:  snap.status = drop_word(0);
            OP_POP_BACK:   snap.status = drop_word(stored_words.size() - 1);
            OP_INSERT:     snap.status = place_word(int'(pos), word);
            OP_ERASE:      snap.status = drop_word(int'(pos));
            OP_CLEAR:      stored_words.delete();
            default: begin
                // Read: position clamped to the last entry, empty queue gives no data.
                if (stored_words.size() != 0) begin
                    idx = (int'(pos) >= stored_words.size()) ? stored_words.size() - 1
                                                              : int'(pos);
                    snap.read_value = stored_words[idx];
                    snap.read_valid = 1'b1;
                end
            end
        endcase
        depth            = stored_words.size();
        snap.count       = CNT_W'(depth);
        snap.is_empty    = (depth == 0);
        snap.front_value = (depth != 0) ? stored_words[0] : '0;
        snap.back_value  = (depth != 0) ? stored_words[depth-1] : '0;
        if (depth > peak_depth)
            peak_depth = depth;
        if (snap.status == ST_FULL)
            full_drops++;
        if (snap.status == ST_EMPTY)
            empty_ignores++;
        return snap;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Called at a rising edge. Waits a random gap, then holds the item until
    // busy is low at an edge. With no gap, start stays high from the previous
    // transfer so it gets only one assignment in this step.
    task automatic issue_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] word);
        int              gap;
        t_queue_snapshot snap;
        gap = back_to_back ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= word;
        do @(posedge i_clk); while (busy);
        snap = perform_queue_op(op, pos, word);
        awaited_snapshots.insert(awaited_snapshots.size(), snap);
        items_sent++;
        op_tally[op]++;
    endtask

    // Sender holds off until every outstanding result has come back.
    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_snapshots.size() != 0);
        repeat (RESULT_LATENCY) @(posedge i_clk);
    endtask

    // Biased op choice: grow favors pushes and inserts, shrink favors removals.
    function automatic logic [OP_W-1:0] pick_operation(input int bias);
        int              roll;
        logic [OP_W-1:0] pick;
        roll = $urandom_range(0, 99);
        if (bias > 0) begin
            if (roll < 22) return OP_PUSH_FRONT;
            if (roll < 44) return OP_PUSH_BACK;
            if (roll < 66) return OP_INSERT;
            if (roll < 80) return OP_READ;
            if (roll < 86) return OP_POP_FRONT;
            if (roll < 92) return OP_POP_BACK;
            if (roll < 99) return OP_ERASE;
            return OP_CLEAR;
        end else if (bias < 0) begin
            if (roll < 22) return OP_POP_FRONT;
            if (roll < 44) return OP_POP_BACK;
            if (roll < 66) return OP_ERASE;
            if (roll < 80) return OP_READ;
            if (roll < 86) return OP_PUSH_FRONT;
            if (roll < 92) return OP_PUSH_BACK;
            if (roll < 99) return OP_INSERT;
            return OP_CLEAR;
        end
        if (roll == 99)
            return OP_CLEAR;
        pick = OP_W'($urandom_range(0, 7));
        return (pick == OP_CLEAR) ? OP_READ : pick;
    endfunction

    // Positions cluster on the live range and its edges, with some anywhere in 0..64.
    function automatic logic [POS_W-1:0] pick_position();
        int depth;
        depth = stored_words.size();
        case ($urandom_range(0, 7))
            0, 1:    return POS_W'($urandom_range(0, CAPACITY));
            2:       return '0;
            3:       return POS_W'(depth);
            4:       return POS_W'((depth > 0) ? depth - 1 : 0);
            5:       return POS_W'(CAPACITY);
            default: return POS_W'($urandom_range(0, depth));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL_ONES;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking: results cannot be held off, so every strobe is taken.
    // ------------------------------------------------------------------

    function automatic void check_field(input string field, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_result
        t_queue_snapshot want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (awaited_snapshots.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, actual count %0d",
                         $time, o_count);
                mismatch_count++;
            end else begin
                want = awaited_snapshots[0];
                awaited_snapshots.delete(0);
                check_field("count",       DATA_W'(want.count),      DATA_W'(o_count));
                check_field("is_empty",    DATA_W'(want.is_empty),   DATA_W'(o_is_empty));
                check_field("front_value", want.front_value,         o_front_value);
                check_field("back_value",  want.back_value,          o_back_value);
                check_field("read_value",  want.read_value,          o_read_value);
                check_field("read_valid",  DATA_W'(want.read_valid), DATA_W'(o_read_valid));
                check_field("status",      DATA_W'(want.status),     DATA_W'(o_status));
                results_checked++;
            end
        end
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Removals and reads on an empty queue; clear when already empty.
    task automatic test_empty_queue();
        issue_op(OP_POP_FRONT, 7'd0, '0);
        issue_op(OP_POP_BACK,  7'd0, '0);
        issue_op(OP_ERASE,     7'd64, ALL_ONES);
        issue_op(OP_READ,      7'd64, '0);
        issue_op(OP_CLEAR,     7'd0, '0);
    endtask

    // Both ends, insert at front/middle/count/past end, clamped erase and read.
    task automatic test_ends_and_positions();
        issue_op(OP_PUSH_BACK,  7'd0,  '0);
        issue_op(OP_PUSH_FRONT, 7'd0,  ALL_ONES);
        issue_op(OP_INSERT,     7'd0,  32'h1111_1111);
        issue_op(OP_INSERT,     7'd64, 32'h2222_2222);
        issue_op(OP_INSERT,     7'd2,  32'hA5A5_A5A5);
        issue_op(OP_INSERT,     7'd5,  32'h5A5A_5A5A);   // position equals count
        issue_op(OP_READ,       7'd0,  '0);
        issue_op(OP_READ,       7'd2,  '0);
        issue_op(OP_READ,       7'd5,  '0);
        issue_op(OP_READ,       7'd64, '0);
        issue_op(OP_ERASE,      7'd64, '0);
        issue_op(OP_ERASE,      7'd0,  '0);
        issue_op(OP_ERASE,      7'd1,  '0);
        issue_op(OP_POP_FRONT,  7'd0,  '0);
        issue_op(OP_POP_BACK,   7'd0,  '0);
        issue_op(OP_CLEAR,      7'd0,  '0);
        issue_op(OP_READ,       7'd0,  '0);
        issue_op(OP_PUSH_BACK,  7'd0,  32'h8000_0001);
        issue_op(OP_READ,       7'd64, '0);
    endtask

    // Fill to capacity, hit every refused push, then empty the queue again.
    task automatic test_full_queue();
        logic [OP_W-1:0] op;
        while (stored_words.size() < CAPACITY) begin
            case ($urandom_range(0, 2))
                0:       op = OP_PUSH_FRONT;
                1:       op = OP_PUSH_BACK;
                default: op = OP_INSERT;
            endcase
            issue_op(op, pick_position(), pick_word());
        end
        // Sender pauses with the queue full until every result is in.
        wait_for_drain();
        issue_op(OP_PUSH_FRONT, 7'd0,  pick_word());
        issue_op(OP_PUSH_BACK,  7'd0,  pick_word());
        issue_op(OP_INSERT,     7'd0,  pick_word());
        issue_op(OP_INSERT,     7'd31, pick_word());
        issue_op(OP_INSERT,     7'd64, pick_word());
        issue_op(OP_READ,       7'd64, '0);
        issue_op(OP_READ,       7'd63, '0);
        issue_op(OP_ERASE,      7'd64, '0);
        issue_op(OP_INSERT,     7'd63, ALL_ONES);
        issue_op(OP_PUSH_BACK,  7'd0,  pick_word());
        while (stored_words.size() > 0) begin
            case ($urandom_range(0, 2))
                0:       op = OP_POP_FRONT;
                1:       op = OP_POP_BACK;
                default: op = OP_ERASE;
            endcase
            issue_op(op, pick_position(), pick_word());
        end
        issue_op(OP_POP_BACK, 7'd0, '0);
        issue_op(OP_ERASE,    7'd0, '0);
        // Refill a little and clear a non-empty queue.
        repeat (20) issue_op(OP_PUSH_BACK, pick_position(), pick_word());
        issue_op(OP_CLEAR, 7'd0, '0);
    endtask

    // Segments of random traffic steered between empty and full, some of
    // them back to back, with a pause for all results every few segments.
    task automatic test_random_traffic();
        int bias;
        for (int seg = 0; seg < 16; seg++) begin
            if (stored_words.size() < 12)
                bias = 1;
            else if (stored_words.size() > 52)
                bias = -1;
            else
                bias = $urandom_range(0, 2) - 1;
            back_to_back = ($urandom_range(0, 3) == 0);
            repeat (64) issue_op(pick_operation(bias), pick_position(), pick_word());
            if (seg % 5 == 4)
                wait_for_drain();
        end
        back_to_back = 1'b0;
    endtask

    initial begin
        for (int k = 0; k < 8; k++)
            op_tally[k] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_ends_and_positions();
        test_full_queue();
        test_random_traffic();

        wait_for_drain();

        $display("Ran %0d transfers: push %0d, pop %0d, insert %0d, erase %0d, clear %0d,",
                 items_sent, op_tally[OP_PUSH_FRONT] + op_tally[OP_PUSH_BACK],
                 op_tally[OP_POP_FRONT] + op_tally[OP_POP_BACK], op_tally[OP_INSERT],
                 op_tally[OP_ERASE], op_tally[OP_CLEAR]);
        $display("read %0d; compared %0d results, peak depth %0d, %0d full, %0d empty.",
                 op_tally[OP_READ], results_checked, peak_depth, full_drops, empty_ignores);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/idq_pkg.sv
hdl/idq_cell.sv
hdl/indexed_double_ended_queue.sv
verif/indexed_double_ended_queue_tb.sv
